>>> hw/rtl/ipv4_receive_header_checker_unit_defines.svh
// Assertion macros shared by the IPv4 receive header checker RTL.
`ifndef IPV4_RECEIVE_HEADER_CHECKER_UNIT_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPV4RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPV4RHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ipv4rhc_pkg.sv
// Types and constants of the IPv4 receive header checker.
`timescale 1ns / 1ps
`default_nettype none
package ipv4rhc_pkg;

    typedef enum logic [2:0] {
        VERDICT_DELIVER        = 3'd0,
        VERDICT_SHORT          = 3'd1,
        VERDICT_BAD_HEADER     = 3'd2,
        VERDICT_BAD_CHECKSUM   = 3'd3,
        VERDICT_NOT_FOR_US     = 3'd4,
        VERDICT_PROTO_UNREACH  = 3'd5
    } verdict_e_t;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Byte offsets of the fixed header fields.
    localparam logic [15:0] OFS_VER_IHL   = 16'd0;
    localparam logic [15:0] OFS_TLEN_HI   = 16'd2;
    localparam logic [15:0] OFS_TLEN_LO   = 16'd3;
    localparam logic [15:0] OFS_PROTO     = 16'd9;
    localparam logic [15:0] OFS_CSUM_HI   = 16'd10;
    localparam logic [15:0] OFS_CSUM_LO   = 16'd11;
    localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
    localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
    localparam logic [15:0] OFS_DST_FIRST = 16'd16;
    localparam logic [15:0] OFS_DST_LAST  = 16'd19;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol_num;
        logic [31:0] source_ip;
        logic [5:0]  header_bytes;
        logic [15:0] payload_length;
    } out_item_t;

    // Header state as it stands once the current byte is taken in.
    typedef struct packed {
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  proto_field;
        logic [15:0] stored_checksum;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] csum_folded;
        logic [15:0] received;
    } hdr_view_t;

endpackage
`default_nettype wire

>>> hw/rtl/ipv4rhc_parse.sv
// Header field capture, byte counter and running ones-complement checksum.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_receive_header_checker_unit_defines.svh"
module ipv4rhc_parse
    import ipv4rhc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output hdr_view_t       view
);

    logic [15:0] byte_count_reg, byte_count_next, count_sat;
    logic [15:0] sum_reg, sum_next, sum_upd;
    logic [7:0]  pending_reg, pending_next, pending_upd;
    logic [7:0]  vihl_reg, vihl_next, vihl_upd;
    logic [15:0] tlen_reg, tlen_next, tlen_upd;
    logic [7:0]  proto_reg, proto_next, proto_upd;
    logic [15:0] csum_reg, csum_next, csum_upd;
    logic [31:0] src_reg, src_next, src_upd;
    logic [31:0] dst_reg, dst_next, dst_upd;
    logic [5:0]  hb;
    logic [7:0]  word_lo;
    logic [16:0] sum17;

    always_comb begin
        vihl_upd    = (byte_count_reg == OFS_VER_IHL) ? in_byte : vihl_reg;
        hb          = {vihl_upd[3:0], 2'b00};
        tlen_upd    = tlen_reg;
        proto_upd   = proto_reg;
        csum_upd    = csum_reg;
        src_upd     = src_reg;
        dst_upd     = dst_reg;
        pending_upd = pending_reg;
        sum_upd     = sum_reg;
        sum17       = 17'd0;

        case (byte_count_reg)
            OFS_TLEN_HI: tlen_upd  = {in_byte, tlen_reg[7:0]};
            OFS_TLEN_LO: tlen_upd  = {tlen_reg[15:8], in_byte};
            OFS_PROTO:   proto_upd = in_byte;
            OFS_CSUM_HI: csum_upd  = {in_byte, csum_reg[7:0]};
            OFS_CSUM_LO: csum_upd  = {csum_reg[15:8], in_byte};
            default: ;
        endcase
        if (byte_count_reg inside {[OFS_SRC_FIRST:OFS_SRC_LAST]}) begin
            src_upd = {src_reg[23:0], in_byte};
        end
        if (byte_count_reg inside {[OFS_DST_FIRST:OFS_DST_LAST]}) begin
            dst_upd = {dst_reg[23:0], in_byte};
        end

        // Checksum field counts as zero; end-around carry keeps a 16-bit sum.
        word_lo = (byte_count_reg inside {OFS_CSUM_HI, OFS_CSUM_LO}) ? 8'd0 : in_byte;
        if (byte_count_reg < {10'd0, hb}) begin
            if (!byte_count_reg[0]) begin
                pending_upd = word_lo;
            end else begin
                sum17   = {1'b0, sum_reg} + {1'b0, pending_reg, word_lo};
                sum_upd = sum17[15:0] + {15'd0, sum17[16]};
            end
        end

        count_sat = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 16'd1 : byte_count_reg;

        view.version_ihl     = vihl_upd;
        view.total_length    = tlen_upd;
        view.proto_field     = proto_upd;
        view.stored_checksum = csum_upd;
        view.source_addr     = src_upd;
        view.dest_addr       = dst_upd;
        view.csum_folded     = sum_upd;
        view.received        = count_sat;

        // Hold when idle, clear after the last byte of a packet.
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        pending_next    = pending_reg;
        vihl_next       = vihl_reg;
        tlen_next       = tlen_reg;
        proto_next      = proto_reg;
        csum_next       = csum_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        if (step) begin
            if (in_last) begin
                byte_count_next = '0;
                sum_next        = '0;
                pending_next    = '0;
                vihl_next       = '0;
                tlen_next       = '0;
                proto_next      = '0;
                csum_next       = '0;
                src_next        = '0;
                dst_next        = '0;
            end else begin
                byte_count_next = count_sat;
                sum_next        = sum_upd;
                pending_next    = pending_upd;
                vihl_next       = vihl_upd;
                tlen_next       = tlen_upd;
                proto_next      = proto_upd;
                csum_next       = csum_upd;
                src_next        = src_upd;
                dst_next        = dst_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            pending_reg    <= '0;
            vihl_reg       <= '0;
            tlen_reg       <= '0;
            proto_reg      <= '0;
            csum_reg       <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            pending_reg    <= pending_next;
            vihl_reg       <= vihl_next;
            tlen_reg       <= tlen_next;
            proto_reg      <= proto_next;
            csum_reg       <= csum_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
        end
    end

    `IPV4RHC_ASSERT_NXT(a_clear_after_last, aclk, aresetn, step && in_last,
        byte_count_reg == 16'd0 && sum_reg == 16'd0, "packet state not cleared after last item")
    `IPV4RHC_ASSERT_NXT(a_count_advance, aclk, aresetn,
        step && !in_last && byte_count_reg != COUNT_MAX,
        byte_count_reg == $past(byte_count_reg) + 16'd1, "byte counter did not advance")

endmodule
`default_nettype wire

>>> hw/rtl/ipv4rhc_verdict.sv
// Verdict decision and the result register.
`timescale 1ns / 1ps
`default_nettype none
module ipv4rhc_verdict
    import ipv4rhc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire logic        m_ready,
    input  wire hdr_view_t   view,
    input  wire logic [31:0] local_ip,
    output logic             m_valid,
    output out_item_t        m_data
);

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;
    verdict_e_t verdict;
    logic [5:0] hb;
    logic       bad_hdr;
    logic [15:0] payload;

    always_comb begin
        hb      = {view.version_ihl[3:0], 2'b00};
        bad_hdr = (view.version_ihl[7:4] != IP_VERSION) ||
                  (view.version_ihl[3:0] < MIN_IHL) ||
                  (view.total_length > view.received) ||
                  ({10'd0, hb} > view.total_length) ||
                  ({10'd0, hb} > view.received);
        payload = '0;
        if (view.received < MIN_HDR_BYTES) begin
            verdict = VERDICT_SHORT;
        end else if (bad_hdr) begin
            verdict = VERDICT_BAD_HEADER;
        end else begin
            payload = view.total_length - {10'd0, hb};
            if (~view.csum_folded != view.stored_checksum) begin
                verdict = VERDICT_BAD_CHECKSUM;
            end else if (view.dest_addr != local_ip) begin
                verdict = VERDICT_NOT_FOR_US;
            end else if (!(view.proto_field inside {PROTO_ICMP, PROTO_UDP})) begin
                verdict = VERDICT_PROTO_UNREACH;
            end else begin
                verdict = VERDICT_DELIVER;
            end
        end

        m_data_next = m_data_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next                = 1'b1;
            m_data_next.verdict         = verdict;
            m_data_next.protocol_num    = view.proto_field;
            m_data_next.source_ip       = view.source_addr;
            m_data_next.header_bytes    = hb;
            m_data_next.payload_length  = payload;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ipv4_receive_header_checker_unit.sv
// Top level of the IPv4 receive header checker.
//
// Usage:
//   s_valid/s_ready/s_data carry one packet byte per item, in wire order,
//   with last_byte set on the final byte of the packet. Every byte is
//   checked against the fixed IPv4 header; on the last byte one result item
//   leaves on m_valid/m_ready/m_data with the verdict, protocol, source
//   address, header length and payload length. Other bytes give no result.
//   cfg_valid/cfg_ready/cfg_data write the local IPv4 address; cfg_ready is
//   always high. Write it only while no packet is in flight.
// Timing:
//   One byte per clock sustained while no last byte is held by a stall. Each
//   byte sits in the input register while the parser and verdict logic
//   settle; a last byte then loads the result register, which drives m_valid.
// Reset (aresetn low, synchronous): the local address reads zero, the
//   packet state clears and both registers empty.
// Stall: while a result waits on m_ready, bytes that are not last still
//   flow; a last byte holds in the input register until the result
//   register frees, and s_ready stays low for as long as it holds.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_receive_header_checker_unit_defines.svh"
module ipv4_receive_header_checker_unit
    import ipv4rhc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_item_reg;
    logic [31:0] local_ip_reg, local_ip_next;
    logic        out_free, advance, s_accept;
    hdr_view_t   view;

    // Advance the held byte unless it is a last byte facing a full result.
    assign out_free  = !m_valid || m_ready;
    assign advance   = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        local_ip_next = cfg_valid ? cfg_data : local_ip_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            local_ip_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            local_ip_reg <= local_ip_next;
        end
    end

    // Payload register: load on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_data;
        end
    end

    ipv4rhc_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_byte (in_item_reg.data_byte),
        .in_last (in_item_reg.last_byte),
        .view    (view)
    );

    ipv4rhc_verdict u_verdict (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && in_item_reg.last_byte),
        .m_ready  (m_ready),
        .view     (view),
        .local_ip (local_ip_reg),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

    `IPV4RHC_ASSERT_IMP(a_mid_bytes_flow, aclk, aresetn,
        in_valid_reg && !in_item_reg.last_byte, advance, "non-last item stalled")
    `IPV4RHC_ASSERT_NXT(a_result_on_last, aclk, aresetn,
        advance && in_item_reg.last_byte, m_valid, "last item gave no result")
    `IPV4RHC_ASSERT_IMP(a_verdict_range, aclk, aresetn, m_valid,
        m_data.verdict <= VERDICT_PROTO_UNREACH, "verdict code out of range")
    `IPV4RHC_ASSERT_NXT(a_no_phantom_result, aclk, aresetn,
        !m_valid && !(advance && in_item_reg.last_byte), !m_valid, "result without last item")

endmodule
`default_nettype wire

>>> verif/ipv4_receive_header_checker_unit_tb.sv
// Self-checking testbench for the IPv4 receive header checker unit.
`timescale 1ns / 1ps
module ipv4_receive_header_checker_unit_tb;
    import ipv4rhc_pkg::*;

    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned PHASE_PACKETS  = 4;
    localparam int unsigned PHASE_BYTES    = 180;
    localparam int unsigned HOLD_AT_PACKET = 3;

    // Tracks header state per byte and holds the verdicts still owed by the block.
    class verdict_scoreboard;
        logic [31:0] local_ip_addr;
        logic [15:0] rx_count;
        logic [20:0] sum_acc;
        logic [7:0]  high_byte;
        logic [7:0]  ver_ihl;
        logic [15:0] tot_len;
        logic [7:0]  proto;
        logic [15:0] csum_field;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        out_item_t   owed_verdicts[$];
        int unsigned mismatch_count;

        function new();
            local_ip_addr  = '0;
            mismatch_count = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            rx_count   = '0;
            sum_acc    = '0;
            high_byte  = '0;
            ver_ihl    = '0;
            tot_len    = '0;
            proto      = '0;
            csum_field = '0;
            src_addr   = '0;
            dst_addr   = '0;
        endfunction

        function void set_local_ip(logic [31:0] addr);
            local_ip_addr = addr;
        endfunction

        function int unsigned pending();
            return owed_verdicts.size();
        endfunction

        function void note_byte(in_item_t item);
            logic [15:0] idx;
            logic [7:0]  b;
            logic [7:0]  v;
            logic [5:0]  hdr_bytes;
            logic [31:0] folded;
            logic [15:0] computed_csum;
            out_item_t   want;
            idx = rx_count;
            b   = item.data_byte;
            if (idx == OFS_VER_IHL) ver_ihl = b;
            hdr_bytes = {ver_ihl[3:0], 2'b00};
            if (idx == OFS_TLEN_HI) tot_len[15:8] = b;
            if (idx == OFS_TLEN_LO) tot_len[7:0] = b;
            if (idx == OFS_PROTO) proto = b;
            if (idx == OFS_CSUM_HI) csum_field[15:8] = b;
            if (idx == OFS_CSUM_LO) csum_field[7:0] = b;
            if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) src_addr = {src_addr[23:0], b};
            if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) dst_addr = {dst_addr[23:0], b};
            // Sum header words with the checksum field counted as zero.
            if (idx < {10'd0, hdr_bytes}) begin
                v = (idx == OFS_CSUM_HI || idx == OFS_CSUM_LO) ? 8'h00 : b;
                if (!idx[0]) high_byte = v;
                else sum_acc = sum_acc + {5'd0, high_byte, v};
            end
            if (rx_count != COUNT_MAX) rx_count = rx_count + 16'd1;
            if (!item.last_byte) return;

            want.protocol_num   = proto;
            want.source_ip      = src_addr;
            want.header_bytes   = hdr_bytes;
            want.payload_length = '0;
            if (rx_count < MIN_HDR_BYTES) begin
                want.verdict = VERDICT_SHORT;
            end else if (ver_ihl[7:4] != IP_VERSION || ver_ihl[3:0] < MIN_IHL ||
                         tot_len > rx_count || {10'd0, hdr_bytes} > tot_len ||
                         {10'd0, hdr_bytes} > rx_count) begin
                want.verdict = VERDICT_BAD_HEADER;
            end else begin
                folded = {16'd0, sum_acc[15:0]} + {27'd0, sum_acc[20:16]};
                folded = {16'd0, folded[15:0]} + {16'd0, folded[31:16]};
                computed_csum = ~folded[15:0];
                want.payload_length = tot_len - {10'd0, hdr_bytes};
                if (computed_csum != csum_field) want.verdict = VERDICT_BAD_CHECKSUM;
                else if (dst_addr != local_ip_addr) want.verdict = VERDICT_NOT_FOR_US;
                else if (proto != PROTO_ICMP && proto != PROTO_UDP)
                    want.verdict = VERDICT_PROTO_UNREACH;
                else want.verdict = VERDICT_DELIVER;
            end
            owed_verdicts.push_back(want);
            clear_packet();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%s differs: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_verdict(out_item_t got);
            out_item_t want;
            if (owed_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result item with no verdict owed: %0h", got);
                return;
            end
            want = owed_verdicts.pop_front();
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("protocol_num", want.protocol_num, got.protocol_num);
            compare_field("source_ip", want.source_ip, got.source_ip);
            compare_field("header_bytes", want.header_bytes, got.header_bytes);
            compare_field("payload_length", want.payload_length, got.payload_length);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    verdict_scoreboard board = new();

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned stall_cycles = 0;
    logic [31:0] cur_local_ip = '0;
    logic [7:0]  pkt_bytes[$];

    ipv4_receive_header_checker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Stall the result channel at the current idle rate; change only on falling edges.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every result item taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_verdict(m_data);
    end

    // Abort when no channel has moved an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Write the local address; the block must be idle when this is called.
    task automatic write_local_ip(input logic [31:0] addr);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_local_ip(addr);
        cur_local_ip = addr;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one byte, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        in_item_t item;
        item.data_byte = value;
        item.last_byte = is_last;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_byte(item);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // Drop valid and hold until every owed verdict is in, then let the pipe settle.
    task automatic pause_until_drained(input int unsigned settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Fill pkt_bytes with a header built from the given fields followed by random bytes.
    function automatic void build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                         input logic [15:0] tot, input logic [7:0] prot,
                                         input logic [31:0] dst, input bit good_csum,
                                         input int unsigned n_bytes);
        logic [7:0]  hdr [0:59];
        logic [31:0] acc;
        logic [15:0] csum;
        int unsigned hb;
        hb = ihl * 4;
        foreach (hdr[i]) hdr[i] = 8'($urandom_range(255));
        hdr[0]  = {ver, ihl};
        hdr[2]  = tot[15:8];
        hdr[3]  = tot[7:0];
        hdr[9]  = prot;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
        acc = '0;
        for (int i = 0; i < hb; i += 2) acc = acc + {16'd0, hdr[i], hdr[i + 1]};
        acc  = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc  = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        csum = ~acc[15:0];
        if (!good_csum) csum = csum ^ 16'($urandom_range(1, 65535));
        hdr[10] = csum[15:8];
        hdr[11] = csum[7:0];
        pkt_bytes.delete();
        for (int i = 0; i < n_bytes; i++)
            pkt_bytes.push_back(i < 60 ? hdr[i] : 8'($urandom_range(255)));
    endfunction

    // Mostly well-formed packets with random content, the rest broken headers and noise.
    task automatic send_random_packet();
        int unsigned pick;
        int unsigned hb;
        int unsigned payload;
        int unsigned pad;
        int unsigned n;
        int unsigned sel;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tot;
        logic [7:0]  prot;
        logic [31:0] dst;
        bit          good;
        pick    = $urandom_range(99);
        ver     = IP_VERSION;
        ihl     = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : MIN_IHL;
        hb      = ihl * 4;
        payload = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(8);
        pad     = $urandom_range(1) ? $urandom_range(1, 4) : 0;
        sel     = $urandom_range(9);
        prot    = (sel < 4) ? PROTO_ICMP : (sel < 8) ? PROTO_UDP : 8'($urandom_range(255));
        sel     = $urandom_range(9);
        dst     = (sel < 8) ? cur_local_ip :
                  (sel == 8) ? cur_local_ip ^ (32'd1 << $urandom_range(31)) : $urandom;
        good    = ($urandom_range(99) < 85);
        tot     = 16'(hb + payload);
        n       = tot + pad;
        if (pick >= 55 && pick < 85) begin
            case ($urandom_range(5))
                0: begin
                    n = $urandom_range(1, MIN_HDR_BYTES - 1);
                end
                1: begin
                    do ver = 4'($urandom_range(15)); while (ver == IP_VERSION);
                end
                2: begin
                    ihl = 4'($urandom_range(MIN_IHL - 1));
                end
                3: begin
                    // total length beyond what arrives
                    tot = 16'(n + $urandom_range(1, 65535 - n));
                end
                4: begin
                    // header runs past the data
                    ihl = 4'd15;
                    n   = $urandom_range(MIN_HDR_BYTES, 59);
                    tot = 16'($urandom_range(n));
                end
                default: begin
                    tot = 16'($urandom_range(hb - 1));
                end
            endcase
        end else if (pick >= 85) begin
            n = $urandom_range(1, 40);
        end
        build_packet(ver, ihl, tot, prot, dst, good, n);
        if (pick >= 85) foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom_range(255));
        send_packet();
    endtask

    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input logic [31:0] addr);
        int unsigned packets;
        int unsigned start_bytes;
        pause_until_drained(DRAIN_CYCLES);
        write_local_ip(addr);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        packets     = 0;
        start_bytes = bytes_sent;
        while (packets < PHASE_PACKETS || bytes_sent - start_bytes < PHASE_BYTES) begin
            send_random_packet();
            packets++;
            if (packets == HOLD_AT_PACKET) pause_until_drained(0);
        end
    endtask

    initial begin
        tx_idle_pct = 29;
        rx_idle_pct = 48;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_local_ip(32'hC0A8_010A);
        // Single-byte packets at both byte extremes, then one clean ICMP packet.
        pkt_bytes = '{8'h00};
        send_packet();
        pkt_bytes = '{8'hFF};
        send_packet();
        build_packet(IP_VERSION, MIN_IHL, 16'd20, PROTO_ICMP, cur_local_ip, 1'b1, 20);
        send_packet();

        run_phase(29, 48, $urandom);
        run_phase(48, 29, 32'h0000_0000);
        run_phase(0, 0, 32'hFFFF_FFFF);

        pause_until_drained(DRAIN_CYCLES);
        if (board.mismatch_count + board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ipv4rhc_pkg.sv
hw/rtl/ipv4rhc_parse.sv
hw/rtl/ipv4rhc_verdict.sv
hw/rtl/ipv4_receive_header_checker_unit.sv
verif/ipv4_receive_header_checker_unit_tb.sv
